FILE: sv/flwf_pkg.sv
// ----------------------------------------------------------------------------
// flwf_pkg
// Shared types and constants of the fastest lap window finder.
// ----------------------------------------------------------------------------
package flwf_pkg;

    localparam int unsigned MAX_LAPS_DEF      = 1024;
    localparam int unsigned LAP_TIME_BITS_DEF = 16;

    // multiplier operand width used by the shift-add unit
    localparam int unsigned MB_W = 17;

    localparam logic [7:0]  POOL_RST   = 8'd25;
    localparam logic [15:0] TARGET_RST = 16'd100;

    typedef enum logic [1:0] {
        REG_POOL   = 2'd0,
        REG_TARGET = 2'd1,
        REG_SETLEN = 2'd2,
        REG_SECS   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]  pool;
        logic [15:0] target;
        logic [10:0] setlen;
        logic [16:0] secs;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_WDIV, S_WIN, S_PATH, S_SUM, S_SLIDE, S_MM,
        S_FBMUL, S_FBDL, S_FBDIV, S_FBSC, S_SCMUL, S_SCDL, S_SCDIV, S_RES
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_WDIV_LD, OP_DIV_STEP, OP_WIN_SAVE, OP_SUM_LD, OP_SLIDE_LD,
        OP_MM_LD, OP_SCAN_STEP, OP_FBMUL_LD, OP_MUL_STEP, OP_FBDIV_LD,
        OP_SCMUL_SRCH, OP_SCMUL_FB, OP_SCDIV_LD, OP_RES_FOUND, OP_RES_NONE
    } t_op;

    typedef enum logic [1:0] {
        SCAN_SUM, SCAN_SLIDE, SCAN_MM
    } t_scan;

    typedef struct packed {
        t_op   op;
        t_scan scan;
        logic  lap_wr;
        logic  out_pending;
    } t_cmd;

    typedef struct packed {
        logic not_found;
        logic search_ok;
        logic scan_done;
        logic ar_last;
    } t_stat;

endpackage

FILE: sv/flwf_ctrl.sv
// ----------------------------------------------------------------------------
// flwf_ctrl
// Sequencer: lap loading, window division, window scans, scaling, result.
// ----------------------------------------------------------------------------
module flwf_ctrl
    import flwf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_has,
    input  logic  i_in_last,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_beat;

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign in_beat     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE:  if (in_beat && i_in_last) n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.not_found) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end else begin
                    n_state = S_WDIV;
                end
            end
            S_WDIV:  if (i_stat.ar_last) n_state = S_WIN;
            S_WIN:   n_state = S_PATH;
            S_PATH:  n_state = i_stat.search_ok ? S_SUM : S_FBMUL;
            S_SUM:   if (i_stat.scan_done) n_state = S_SLIDE;
            S_SLIDE: if (i_stat.scan_done) n_state = S_MM;
            S_MM:    if (i_stat.scan_done) n_state = S_SCMUL;
            S_FBMUL: if (i_stat.ar_last) n_state = S_FBDL;
            S_FBDL:  n_state = S_FBDIV;
            S_FBDIV: if (i_stat.ar_last) n_state = S_FBSC;
            S_FBSC:  n_state = S_SCMUL;
            S_SCMUL: if (i_stat.ar_last) n_state = S_SCDL;
            S_SCDL:  n_state = S_SCDIV;
            S_SCDIV: if (i_stat.ar_last) n_state = S_RES;
            S_RES: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd             = '0;
        o_cmd.op          = OP_NONE;
        o_cmd.scan        = SCAN_SUM;
        o_cmd.lap_wr      = in_beat && i_in_has;
        o_cmd.out_pending = r_out_valid;
        case (r_state)
            S_CHECK: o_cmd.op = i_stat.not_found ? OP_RES_NONE : OP_WDIV_LD;
            S_WDIV:  o_cmd.op = OP_DIV_STEP;
            S_WIN:   o_cmd.op = OP_WIN_SAVE;
            S_PATH:  o_cmd.op = i_stat.search_ok ? OP_SUM_LD : OP_FBMUL_LD;
            S_SUM: begin
                o_cmd.scan = SCAN_SUM;
                o_cmd.op   = i_stat.scan_done ? OP_SLIDE_LD : OP_SCAN_STEP;
            end
            S_SLIDE: begin
                o_cmd.scan = SCAN_SLIDE;
                o_cmd.op   = i_stat.scan_done ? OP_MM_LD : OP_SCAN_STEP;
            end
            S_MM: begin
                o_cmd.scan = SCAN_MM;
                o_cmd.op   = i_stat.scan_done ? OP_SCMUL_SRCH : OP_SCAN_STEP;
            end
            S_FBMUL: o_cmd.op = OP_MUL_STEP;
            S_FBDL:  o_cmd.op = OP_FBDIV_LD;
            S_FBDIV: o_cmd.op = OP_DIV_STEP;
            S_FBSC:  o_cmd.op = OP_SCMUL_FB;
            S_SCMUL: o_cmd.op = OP_MUL_STEP;
            S_SCDL:  o_cmd.op = OP_SCDIV_LD;
            S_SCDIV: o_cmd.op = OP_DIV_STEP;
            S_RES:   o_cmd.op = OP_RES_FOUND;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

FILE: sv/flwf_dpath.sv
// ----------------------------------------------------------------------------
// flwf_dpath
// Lap store, window scans, shift-add multiplier and restoring divider.
// ----------------------------------------------------------------------------
module flwf_dpath
    import flwf_pkg::*;
#(
    parameter int unsigned MAX_LAPS      = MAX_LAPS_DEF,
    parameter int unsigned LAP_TIME_BITS = LAP_TIME_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  t_cmd                     i_cmd,
    input  logic [LAP_TIME_BITS-1:0] i_lap,
    output t_stat                    o_stat,
    output logic                     o_found,
    output logic [25:0]              o_dur,
    output logic [15:0]              o_spread,
    output logic [17:0]              o_cov
);

    localparam int unsigned LTB  = LAP_TIME_BITS;
    localparam int unsigned AW   = $clog2(MAX_LAPS);
    localparam int unsigned AW1  = $clog2(MAX_LAPS + 1);
    localparam int unsigned CW   = $clog2(MAX_LAPS + 2);
    localparam int unsigned SUMW = LTB + CW;
    localparam int unsigned DW   = (SUMW > 31) ? SUMW : 31;
    localparam int unsigned PW   = DW + MB_W;
    localparam int unsigned NW   = $clog2(PW + 1);
    localparam int unsigned EW   = (CW > 11) ? CW : 11;

    logic [LTB-1:0]  mem [MAX_LAPS];
    logic [CW-1:0]   r_count;
    logic [LTB-1:0]  r_rda, r_rdb;
    logic [AW1-1:0]  r_idx, r_end, r_pidx, r_bstart;
    logic            r_pv;
    logic [SUMW-1:0] r_sum, r_best;
    logic [LTB-1:0]  r_lo, r_hi;
    logic [16:0]     r_win, r_cov;
    logic [PW-1:0]   r_acc, r_ma;
    logic [MB_W-1:0] r_mb;
    logic [16:0]     r_dv;
    logic [17:0]     r_rem;
    logic [NW-1:0]   r_cnt;
    logic            r_found;
    logic [25:0]     r_dur;
    logic [LTB-1:0]  r_spread;
    logic [17:0]     r_covd;

    logic [AW1-1:0]  rdb_idx;
    logic            issue;
    logic [SUMW-1:0] nsum;
    logic [17:0]     dtry;
    logic            dbit;
    logic [24:0]     cov_full;
    logic [18:0]     cover_chk;
    logic [31:0]     spread32;

    assign rdb_idx   = r_idx - AW1'(r_win);
    assign issue     = (i_cmd.op == OP_SCAN_STEP) && (r_idx != r_end);
    assign nsum      = r_sum + SUMW'(r_rda) - SUMW'(r_rdb);
    assign dtry      = {r_rem[16:0], r_acc[PW-1]};
    assign dbit      = (dtry >= {1'b0, r_dv});
    assign cov_full  = r_acc[16:0] * i_cfg.pool;
    assign cover_chk = i_cfg.pool * i_cfg.setlen;
    assign spread32  = 32'(r_spread);

    assign o_stat.not_found = (i_cfg.pool == '0) || (i_cfg.target == '0) ||
                              (cover_chk < {3'b0, i_cfg.target});
    assign o_stat.search_ok = (r_count <= CW'(MAX_LAPS)) &&
                              (EW'(r_count) == EW'(i_cfg.setlen));
    assign o_stat.scan_done = (r_idx == r_end) && !r_pv;
    assign o_stat.ar_last   = (r_cnt == NW'(1));

    assign o_found  = r_found;
    assign o_dur    = r_dur;
    assign o_spread = spread32[15:0];
    assign o_cov    = r_covd;

    // lap store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.lap_wr && (r_count < CW'(MAX_LAPS))) begin
            mem[r_count[AW-1:0]] <= i_lap;
        end
        r_rda <= mem[r_idx[AW-1:0]];
        r_rdb <= mem[rdb_idx[AW-1:0]];
    end

    // control-side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pv    <= 1'b0;
            r_cnt   <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.lap_wr) begin
                if (r_count < CW'(MAX_LAPS)) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_count <= CW'(MAX_LAPS + 1);
                end
            end
            r_pv <= issue;
            case (i_cmd.op)
                OP_WDIV_LD, OP_FBDIV_LD, OP_SCDIV_LD: r_cnt <= NW'(PW);
                OP_FBMUL_LD, OP_SCMUL_SRCH, OP_SCMUL_FB: r_cnt <= NW'(MB_W);
                OP_DIV_STEP, OP_MUL_STEP: r_cnt <= r_cnt - NW'(1);
                OP_RES_FOUND: begin
                    r_found <= 1'b1;
                    r_count <= '0;
                end
                OP_RES_NONE: begin
                    r_found <= 1'b0;
                    r_count <= '0;
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_idx  <= r_idx + AW1'(1);
            r_pidx <= r_idx;
        end
        case (i_cmd.op)
            OP_WDIV_LD: begin
                r_acc <= PW'(17'(i_cfg.target) + 17'(i_cfg.pool) - 17'd1);
                r_dv  <= 17'(i_cfg.pool);
                r_rem <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= dbit ? (dtry - {1'b0, r_dv}) : dtry;
                r_acc <= {r_acc[PW-2:0], dbit};
            end
            OP_WIN_SAVE: begin
                r_win <= r_acc[16:0];
                r_cov <= cov_full[16:0];
            end
            OP_SUM_LD: begin
                r_idx <= '0;
                r_end <= AW1'(r_win);
                r_sum <= '0;
            end
            OP_SLIDE_LD: begin
                r_best   <= r_sum;
                r_bstart <= '0;
                r_end    <= AW1'(r_count);
            end
            OP_MM_LD: begin
                r_idx <= r_bstart;
                r_end <= r_bstart + AW1'(r_win);
                r_lo  <= '1;
                r_hi  <= '0;
            end
            OP_SCAN_STEP: begin
                if (r_pv) begin
                    case (i_cmd.scan)
                        SCAN_SUM: r_sum <= r_sum + SUMW'(r_rda);
                        SCAN_SLIDE: begin
                            r_sum <= nsum;
                            if (nsum < r_best) begin
                                r_best   <= nsum;
                                r_bstart <= r_pidx - AW1'(r_win) + AW1'(1);
                            end
                        end
                        SCAN_MM: begin
                            if (r_rda < r_lo) r_lo <= r_rda;
                            if (r_rda > r_hi) r_hi <= r_rda;
                        end
                        default: ;
                    endcase
                end
            end
            OP_FBMUL_LD: begin
                r_acc <= '0;
                r_ma  <= PW'(i_cfg.secs);
                r_mb  <= MB_W'(r_win);
            end
            OP_MUL_STEP: begin
                if (r_mb[0]) r_acc <= r_acc + r_ma;
                r_ma <= {r_ma[PW-2:0], 1'b0};
                r_mb <= {1'b0, r_mb[MB_W-1:1]};
            end
            OP_FBDIV_LD: begin
                r_dv  <= 17'(i_cfg.setlen);
                r_rem <= '0;
            end
            OP_SCMUL_SRCH: begin
                r_acc <= '0;
                r_ma  <= PW'(r_best);
                r_mb  <= MB_W'(i_cfg.target);
            end
            OP_SCMUL_FB: begin
                r_acc <= '0;
                r_ma  <= {r_acc[PW-4:0], 3'b000};
                r_mb  <= MB_W'(i_cfg.target);
                r_lo  <= '0;
                r_hi  <= '0;
            end
            OP_SCDIV_LD: begin
                r_dv  <= r_cov;
                r_rem <= '0;
            end
            OP_RES_FOUND: begin
                r_dur    <= r_acc[25:0];
                r_spread <= r_hi - r_lo;
                r_covd   <= 18'(r_cov);
            end
            OP_RES_NONE: begin
                r_dur    <= '0;
                r_spread <= '0;
                r_covd   <= '0;
            end
            default: ;
        endcase
    end

endmodule

FILE: sv/fastest_lap_window_finder_core.sv
// ----------------------------------------------------------------------------
// fastest_lap_window_finder_core
// Finds the fastest run of laps covering a target distance in a swim set.
// ----------------------------------------------------------------------------
// Usage:
//  - Config over APB (pool length, target, set lengths, set seconds), written
//    while the block is idle. pready is always high.
//  - Input stream: one lap per beat (tdata = lap_time, tuser = has_time,
//    tlast ends the set). Non-last beats take one cycle each while no result is pending.
//  - On the last beat a single result beat follows (tuser = found). The divider
//    and multiplier are shared and work one bit per cycle; a division runs over
//    PW = max(LAP_TIME_BITS + clog2(MAX_LAPS+2), 31) + 17 bits (48 by default).
//  - Input is held off (tready low) from the last beat until the result beat
//    has been taken; a stalled result simply waits in its output register.
//  - Reset clears the lap count and config to defaults; the lap store is not
//    cleared, only entries of the current set are read.
// ----------------------------------------------------------------------------
module fastest_lap_window_finder_core
    import flwf_pkg::*;
#(
    parameter int unsigned MAX_LAPS      = MAX_LAPS_DEF,
    parameter int unsigned LAP_TIME_BITS = LAP_TIME_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [LAP_TIME_BITS-1:0] lap_time, zero padded to bytes
    input  logic [((LAP_TIME_BITS+7)/8)*8-1:0]  i_s_axis_tdata,
    // [0] has_time
    input  logic                                i_s_axis_tuser,
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [25:0] best_duration, [41:26] best_spread, [59:42] covered_distance
    output logic [63:0]                         o_m_axis_tdata,
    // [0] found
    output logic                                o_m_axis_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    t_cfg        r_cfg;
    t_cmd        cmd;
    t_stat       stat;
    t_reg_idx    reg_idx;
    logic [25:0] dur;
    logic [15:0] spread;
    logic [17:0] cov;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pool   <= POOL_RST;
            r_cfg.target <= TARGET_RST;
            r_cfg.setlen <= '0;
            r_cfg.secs   <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_POOL:   r_cfg.pool   <= pwdata[7:0];
                REG_TARGET: r_cfg.target <= pwdata[15:0];
                REG_SETLEN: r_cfg.setlen <= pwdata[10:0];
                REG_SECS:   r_cfg.secs   <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_POOL:   prdata = 32'(r_cfg.pool);
            REG_TARGET: prdata = 32'(r_cfg.target);
            REG_SETLEN: prdata = 32'(r_cfg.setlen);
            REG_SECS:   prdata = 32'(r_cfg.secs);
            default:    prdata = '0;
        endcase
    end

    flwf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_has    (i_s_axis_tuser),
        .i_in_last   (i_s_axis_tlast),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    flwf_dpath #(
        .MAX_LAPS      (MAX_LAPS),
        .LAP_TIME_BITS (LAP_TIME_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cmd    (cmd),
        .i_lap    (i_s_axis_tdata[LAP_TIME_BITS-1:0]),
        .o_stat   (stat),
        .o_found  (o_m_axis_tuser),
        .o_dur    (dur),
        .o_spread (spread),
        .o_cov    (cov)
    );

    assign o_m_axis_tdata = {4'b0000, cov, spread, dur};

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_m_axis_tvalid && o_s_axis_tready))
        else $error("input taken while result pending");

    a_zero_when_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == 64'd0))
        else $error("not-found result carries data");

    a_ready_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready) |=> o_s_axis_tready)
        else $error("input not reopened after result beat");
`endif

endmodule

FILE: test/fastest_lap_window_finder_core_test.sv
// ----------------------------------------------------------------------------
// fastest_lap_window_finder_core_test
// Self-checking bench: streams lap sets through the core under several
// register settings and random stalls, and compares every result beat with a
// local model of the fastest-window search and its fallback.
// ----------------------------------------------------------------------------
module fastest_lap_window_finder_core_test;
    import flwf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLAPS = 1024;
    localparam int LIMIT = 3000000;

    typedef struct packed {
        logic        found;
        logic [25:0] dur;
        logic [15:0] spread;
        logic [17:0] covered;
    } t_lap_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_data = '0;
    logic        s_user = 1'b0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_data;
    logic        m_user;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fastest_lap_window_finder_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user), .i_s_axis_tlast(s_last),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    // model state
    logic [15:0] laps [NLAPS];
    int unsigned lap_cnt;
    t_cfg        cfg;
    t_lap_result expected_results[$];

    int  errors;
    int  cycles;
    int  results_seen;
    bit  calm;       // no random idling
    int  hold_off;   // receiver stall cycles left

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
            results_seen);
        errors++;
    endtask

    function automatic t_lap_result predict_set_end();
        t_lap_result r;
        longint unsigned w, cov, d, sum, best;
        int start;
        logic [15:0] lo, hi;
        r = '0;
        if (cfg.pool == 0 || cfg.target == 0 ||
            longint'(cfg.pool) * cfg.setlen < cfg.target) return r;
        w = (longint'(cfg.target) + cfg.pool - 1) / cfg.pool;
        cov = w * cfg.pool;
        if (lap_cnt <= NLAPS && lap_cnt == cfg.setlen) begin
            sum = 0;
            start = 0;
            for (int i = 0; i < int'(w); i++) sum += laps[i];
            best = sum;
            for (int i = int'(w); i < int'(lap_cnt); i++) begin
                sum = sum + laps[i] - laps[i - int'(w)];
                if (sum < best) begin
                    best = sum;
                    start = i - int'(w) + 1;
                end
            end
            lo = laps[start];
            hi = lo;
            for (int i = start; i < start + int'(w); i++) begin
                if (laps[i] < lo) lo = laps[i];
                if (laps[i] > hi) hi = laps[i];
            end
            d = best;
            r.spread = hi - lo;
        end else begin
            d = 8 * ((longint'(cfg.secs) * w) / cfg.setlen);
        end
        d = (d * cfg.target) / cov;
        r.found = 1'b1;
        r.dur = d[25:0];
        r.covered = cov[17:0];
        return r;
    endfunction

    // called at a falling edge; leaves tvalid high so the next beat can follow
    task automatic send_beat(input logic [15:0] t, input logic has, input logic lst);
        while (!calm && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= t;
        s_user <= has;
        s_last <= lst;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        if (has) begin
            if (lap_cnt < NLAPS) begin
                laps[lap_cnt] = t;
                lap_cnt++;
            end else lap_cnt = NLAPS + 1;
        end
        if (lst) begin
            expected_results.push_back(predict_set_end());
            lap_cnt = 0;
        end
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_POOL:   cfg.pool = v[7:0];
            REG_TARGET: cfg.target = v[15:0];
            REG_SETLEN: cfg.setlen = v[10:0];
            REG_SECS:   cfg.secs = v[16:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_cfg(input int p, input int t, input int n, input int s);
        drain();
        write_reg(REG_POOL, p);
        write_reg(REG_TARGET, t);
        write_reg(REG_SETLEN, n);
        write_reg(REG_SECS, s);
    endtask

    // n laps; lap times in [lo, hi]; terminator-only last beat if term set or n is 0
    task automatic send_set(input int n, input int lo, input int hi, input bit term);
        for (int i = 0; i < n; i++)
            send_beat(16'($urandom_range(hi, lo)), 1'b1, !term && i == n - 1);
        if (term || n == 0) send_beat(16'($urandom), 1'b0, 1'b1);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random idling plus a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) m_ready <= 1'b0;
        else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else m_ready <= calm || $urandom_range(99) >= 9;
    end

    always @(posedge i_clk) begin
        t_lap_result want;
        if (i_rst_n && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_user !== want.found) report("found", m_user, want.found);
                if (m_data[25:0] !== want.dur) report("duration", m_data[25:0], want.dur);
                if (m_data[41:26] !== want.spread)
                    report("spread", m_data[41:26], want.spread);
                if (m_data[59:42] !== want.covered)
                    report("covered", m_data[59:42], want.covered);
            end
            results_seen++;
        end
    end

    task automatic test_reset_defaults();
        // set_lengths is 0 after reset, so nothing is covered
        send_set(3, 0, 65535, 0);
        send_set(0, 0, 0, 1);
    endtask

    task automatic test_directed();
        set_cfg(25, 100, 6, 86399);
        send_beat(16'hFFFF, 1, 0);
        send_beat(16'h0000, 1, 0);
        send_beat(16'h0001, 1, 0);
        send_beat(16'h8000, 1, 0);
        send_beat(16'h7FFF, 1, 0);
        send_beat(16'h5555, 1, 1);
        // count differs from set_lengths: fallback
        send_set(4, 0, 65535, 1);
        set_cfg(255, 65535, 1024, 86399);
        send_set(3, 0, 65535, 0);
        set_cfg(1, 1, 2, 0);
        send_set(2, 0, 65535, 1);
        send_set(2, 65535, 65535, 0);
        set_cfg(1, 5, 4, 100);    // not found
        send_set(4, 0, 65535, 0);
        set_cfg(3, 7, 3, 0);      // window equals set
        send_set(3, 0, 65535, 0);
    endtask

    task automatic test_overflow();
        set_cfg(1, 3, 1024, 86399);
        send_set(1024, 0, 65535, 1);
        send_set(1030, 0, 65535, 0);
    endtask

    task automatic test_backpressure();
        set_cfg(10, 40, 5, 300);
        hold_off = 400;
        for (int i = 0; i < 8; i++) send_set(5, 0, 65535, 0);
    endtask

    task automatic test_random(input int items);
        int sent, n, w;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(3) == 0) begin
                w = $urandom_range(8, 1);
                n = $urandom_range(12, w);
                set_cfg($urandom_range(255, 1), 0, 0, 0);
                write_reg(REG_TARGET, $urandom_range(w * cfg.pool, (w - 1) * cfg.pool + 1));
                write_reg(REG_SETLEN, $urandom_range(3) == 0 ? $urandom_range(16) : n);
                write_reg(REG_SECS, $urandom_range(86399));
            end else n = cfg.setlen == 0 ? $urandom_range(6) : cfg.setlen;
            if ($urandom_range(4) == 0) n = $urandom_range(12);
            calm = (sent > items / 3 && sent < items / 2);
            if ($urandom_range(1)) send_set(n, 0, 65535, $urandom_range(1));
            else send_set(n, 600, 900, $urandom_range(1));
            sent += n + 1;
        end
        calm = 0;
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        results_seen = 0;
        calm = 0;
        hold_off = 0;
        lap_cnt = 0;
        cfg = '{pool: POOL_RST, target: TARGET_RST, setlen: '0, secs: '0};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_overflow();
        test_backpressure();
        test_random(600);
        drain();
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
